// File: rtl/core/bpss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpss_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SKIP_W     = 5;
  localparam int unsigned OUT_OFF_W  = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2,
    CFG_NON_OVERLAP    = 2'd3
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    logic                 match_found;
    logic [OUT_OFF_W-1:0] match_offset;
    logic                 stream_done;
    logic                 any_found;
    logic [COUNT_W-1:0]   match_total;
  } res_t;

  // Front to queue push request
  typedef struct packed {
    logic valid;
    res_t item;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/bpss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bpss_front
  import bpss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [BYTE_W-1:0]               data_byte_i,
  input  wire logic                            first_byte_i,
  input  wire logic                            last_byte_i,
  // configuration
  input  wire logic [LEN_W-1:0]                pat_len_i,
  input  wire logic [MAX_PATTERN*BYTE_W-1:0]   pat_bytes_i,
  input  wire logic                            non_overlap_i,
  // queue side
  input  wire logic                            q_full_i,
  output push_t                                push_o
);

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
  logic [BYTE_W-1:0]      win_d [MAX_PATTERN];
  logic [FILL_W-1:0]      fill_q, fill_d, fill_base;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, here;
  logic [SKIP_W-1:0]      skip_q, skip_d, skip_base;
  logic [COUNT_W-1:0]     cnt_q, cnt_d, cnt_base;

  logic [LEN_W-1:0]       eff_len, len_m1;
  logic [BYTE_W-1:0]      pat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pos_eq;
  logic                   fill_ok, found, accept;
  logic [OFFSET_BITS-1:0] len_m1_ext, off_full;
  logic [OFFSET_BITS+OUT_OFF_W-1:0] off_wide;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Effective pattern length: zero acts as one, clamp at the window depth
  always_comb begin
    if (pat_len_i == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_i > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pat_len_i;
    end
  end
  assign len_m1 = eff_len - LEN_W'(1);

  // Stream restart zeroes state ahead of this byte
  assign fill_base = first_byte_i ? '0 : fill_q;
  assign here      = first_byte_i ? '0 : pos_q;
  assign skip_base = first_byte_i ? '0 : skip_q;
  assign cnt_base  = first_byte_i ? '0 : cnt_q;

  // Shifted window, newest byte at index 0
  always_comb begin
    win_d[0] = data_byte_i;
    for (int unsigned j = 1; j < MAX_PATTERN; j++) begin
      win_d[j] = first_byte_i ? '0 : win_q[j-1];
    end
  end

  assign fill_d = (fill_base == FILL_W'(MAX_PATTERN)) ? fill_base : fill_base + FILL_W'(1);
  assign pos_d  = (here == '1) ? here : here + OFFSET_BITS'(1);

  // Parallel compare: window slot j holds pattern byte len-1-j
  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cmp
      logic [LEN_W-1:0] pidx;
      assign pat[g]    = pat_bytes_i[g*BYTE_W +: BYTE_W];
      assign pidx      = len_m1 - LEN_W'(g);
      assign pos_eq[g] = (LEN_W'(g) >= eff_len) || (win_d[g] == pat[pidx[PIDX_W-1:0]]);
    end
  endgenerate

  assign fill_ok = LEN_W'(fill_d) >= eff_len;
  assign found   = (skip_base == '0) && fill_ok && (&pos_eq);

  // Skip countdown, armed on a match in non-overlapping mode
  always_comb begin
    if (skip_base != '0) begin
      skip_d = skip_base - SKIP_W'(1);
    end else if (found && non_overlap_i) begin
      skip_d = SKIP_W'(len_m1);
    end else begin
      skip_d = '0;
    end
  end

  assign cnt_d = (found && (cnt_base != '1)) ? cnt_base + COUNT_W'(1) : cnt_base;

  // Start offset, clipped at zero, reported in 32 bits
  assign len_m1_ext = OFFSET_BITS'(len_m1);
  assign off_full   = (here >= len_m1_ext) ? here - len_m1_ext : '0;
  assign off_wide   = {{OUT_OFF_W{1'b0}}, off_full};

  always_comb begin
    push_o.valid             = accept && (found || last_byte_i);
    push_o.item.match_found  = found;
    push_o.item.match_offset = found ? off_wide[OUT_OFF_W-1:0] : '0;
    push_o.item.stream_done  = last_byte_i;
    push_o.item.any_found    = last_byte_i && (cnt_d != '0);
    push_o.item.match_total  = cnt_d;
  end

  // Search state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      skip_q <= '0;
      cnt_q  <= '0;
      for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= '0;
      end
    end else if (accept) begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      skip_q <= skip_d;
      cnt_q  <= cnt_d;
      for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

`ifndef SYNTHESIS
  // Skip never reaches past a full pattern length
  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q < SKIP_W'(MAX_PATTERN))
    else $error("skip counter out of range");

  // A match on a restart byte is the first of its stream
  a_first_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && first_byte_i && found) |-> (cnt_d == COUNT_W'(1)))
    else $error("match total wrong after stream restart");

  // While skipping, no match is reported
  a_skip_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !first_byte_i && (skip_q != '0)) |-> !found)
    else $error("match reported inside skip window");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bpss_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bpss_queue
  import bpss_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output res_t       head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == CNT_W'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  assign do_push = push_i.valid;
  assign do_pop  = out_valid_o && !out_stall_i;

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

`ifndef SYNTHESIS
  // Front must hold off while the queue is full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i.valid)
    else $error("push into full result queue");

  // Count tracks push and pop
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("result queue count lost a push");
`endif

endmodule

`default_nettype wire

// File: rtl/core/byte_pattern_stream_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming byte-pattern search. Each input item is one stream byte; the block
// reports the start offset of every occurrence of the configured pattern
// (1 to MAX_PATTERN bytes) with a result item at the byte where the occurrence
// ends, plus a result item on every byte marked last_byte (carrying the running
// match total and any_found). first_byte restarts offset, window and count.
// With non_overlapping set, occurrences overlapping the last reported one are
// dropped. One item is taken every cycle while the queue is not full: the front
// end shifts the window, does the full parallel compare and updates offset,
// skip and count within the accepting cycle, then pushes the result into a
// two-entry queue that feeds the output; input stall rises only while that
// queue is full. Configuration must be written with cfg_we_i only while the
// block is idle (the block itself does not enforce this) and applies from the next byte.

module byte_pattern_stream_search_top
  import bpss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     data_byte_i,
  input  wire logic                  first_byte_i,
  input  wire logic                  last_byte_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       match_found_o,
  output logic [OUT_OFF_W-1:0]       match_offset_o,
  output logic                       stream_done_o,
  output logic                       any_found_o,
  output logic [COUNT_W-1:0]         match_total_o
);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned HALF_BYTES  = CFG_DATA_W / BYTE_W;

  logic [LEN_W-1:0]                len_q;
  logic [MAX_PATTERN*BYTE_W-1:0]   pat_q;
  logic                            nonovl_q;
  push_t                           push;
  logic                            q_full;
  res_t                            head;

  // Configuration registers; pattern bytes kept only up to the window depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_W'(1);
      pat_q    <= '0;
      nonovl_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_LENGTH: len_q <= cfg_data_i[LEN_W-1:0];
        CFG_PATTERN_LOW: begin
          for (int unsigned k = 0; k < MAX_PATTERN; k++) begin
            if (k < HALF_BYTES) begin
              pat_q[k*BYTE_W +: BYTE_W] <= cfg_data_i[k*BYTE_W +: BYTE_W];
            end
          end
        end
        CFG_PATTERN_HIGH: begin
          for (int unsigned k = HALF_BYTES; k < MAX_PATTERN; k++) begin
            pat_q[k*BYTE_W +: BYTE_W] <= cfg_data_i[(k-HALF_BYTES)*BYTE_W +: BYTE_W];
          end
        end
        CFG_NON_OVERLAP: nonovl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bpss_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .pat_len_i     (len_q),
    .pat_bytes_i   (pat_q),
    .non_overlap_i (nonovl_q),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  bpss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // Unpack the head result onto the output fields
  assign match_found_o  = head.match_found;
  assign match_offset_o = head.match_offset;
  assign stream_done_o  = head.stream_done;
  assign any_found_o    = head.any_found;
  assign match_total_o  = head.match_total;

`ifndef SYNTHESIS
  // A reported match always counts in the total
  a_found_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && match_found_o) |-> (match_total_o != '0))
    else $error("match reported with zero total");
`endif

endmodule

`default_nettype wire

// File: tb/tb_byte_pattern_stream_search_top.sv
`timescale 1ns / 1ps

module tb_byte_pattern_stream_search_top;
  import bpss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned DRAIN_CYCLES = 5;
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } stream_byte_t;

  // DUT ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     data_byte_i;
  logic                  first_byte_i;
  logic                  last_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  match_found_o;
  logic [OUT_OFF_W-1:0]  match_offset_o;
  logic                  stream_done_o;
  logic                  any_found_o;
  logic [COUNT_W-1:0]    match_total_o;

  // bytes waiting to be sent, and search results still owed by the DUT
  stream_byte_t pending_bytes[$];
  res_t         expected_hits[$];

  // predictor: register mirror and search state
  logic [4:0]  cfg_len;
  logic [63:0] cfg_low;
  logic [63:0] cfg_high;
  logic        cfg_nonov;
  logic [7:0]  win_bytes[16];
  logic [31:0] next_pos;
  int unsigned fill_cnt;
  int unsigned skip_cnt;
  logic [31:0] hit_cnt;

  // stimulus side copy of the current pattern
  logic [7:0]  gen_pat[16];
  int unsigned gen_len;

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned bytes_queued;
  logic        in_taken;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stall_tick;
  stream_byte_t drive_byte;
  logic        step_emit;
  res_t        step_res;
  res_t        want;

  byte_pattern_stream_search_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_found_o (match_found_o),
    .match_offset_o(match_offset_o),
    .stream_done_o (stream_done_o),
    .any_found_o   (any_found_o),
    .match_total_o (match_total_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the search by one byte; emit is set when the byte yields a result.
  task automatic scan_byte(input logic [7:0] b, input logic first, input logic last,
                           output logic emit, output res_t r);
    int unsigned plen;
    int unsigned k;
    logic [31:0] here;
    logic [7:0]  pb;
    logic        found;
    logic        same;
    begin
      found = 1'b0;
      r = '0;
      if (first) begin
        for (k = 0; k < 16; k++) win_bytes[k] = 8'h00;
        next_pos = '0;
        fill_cnt = 0;
        skip_cnt = 0;
        hit_cnt = '0;
      end
      plen = (cfg_len == 0) ? 1 : ((cfg_len > 16) ? 16 : cfg_len);
      here = next_pos;
      for (k = 15; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = b;
      if (fill_cnt < 16) fill_cnt++;
      if (next_pos != POS_MAX) next_pos++;

      if (skip_cnt > 0) begin
        skip_cnt--;
      end else if (fill_cnt >= plen) begin
        same = 1'b1;
        for (k = 0; k < plen; k++) begin
          pb = (k < 8) ? cfg_low[8*k +: 8] : cfg_high[8*(k-8) +: 8];
          if (pb != win_bytes[plen-1-k]) same = 1'b0;
        end
        if (same) begin
          found = 1'b1;
          r.match_offset = (here >= plen - 1) ? here - (plen - 1) : '0;
          if (hit_cnt != TOTAL_MAX) hit_cnt++;
          if (cfg_nonov) skip_cnt = plen - 1;
        end
      end
      emit = found || last;
      r.match_found = found;
      r.stream_done = last;
      r.any_found = last && (hit_cnt != 0);
      r.match_total = hit_cnt;
    end
  endtask

  // Monitor: mirror register writes, predict accepted bytes, check results.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_len = 5'd1;
      cfg_low = '0;
      cfg_high = '0;
      cfg_nonov = 1'b0;
      for (int i = 0; i < 16; i++) win_bytes[i] = 8'h00;
      next_pos = '0;
      fill_cnt = 0;
      skip_cnt = 0;
      hit_cnt = '0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LENGTH: cfg_len = cfg_data_i[4:0];
          CFG_PATTERN_LOW:    cfg_low = cfg_data_i;
          CFG_PATTERN_HIGH:   cfg_high = cfg_data_i;
          CFG_NON_OVERLAP:    cfg_nonov = cfg_data_i[0];
          default: ;
        endcase
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        scan_byte(data_byte_i, first_byte_i, last_byte_i, step_emit, step_res);
        if (step_emit) expected_hits.insert(expected_hits.size(), step_res);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_hits.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result found=%0b off=%0d done=%0b any=%0b total=%0d",
                     $time, match_found_o, match_offset_o, stream_done_o, any_found_o,
                     match_total_o);
        end else begin
          want = expected_hits.pop_front();
          if (match_found_o !== want.match_found || match_offset_o !== want.match_offset ||
              stream_done_o !== want.stream_done || any_found_o !== want.any_found ||
              match_total_o !== want.match_total) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result mismatch exp found=%0b off=%0d done=%0b any=%0b total=%0d",
                       $time, want.match_found, want.match_offset, want.stream_done,
                       want.any_found, want.match_total, " | got found=%0b off=%0d done=%0b",
                       match_found_o, match_offset_o, stream_done_o,
                       " any=%0b total=%0d", any_found_o, match_total_o);
          end
        end
      end
    end
  end

  // Driver: bytes go out in bursts with gaps; the result side stalls by mode.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0 || pending_bytes.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        drive_byte = pending_bytes.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= drive_byte.data;
        first_byte_i <= drive_byte.first;
        last_byte_i <= drive_byte.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        end
      end
    end
    if (stall_tick == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_tick = $urandom_range(20, 80);
    end else begin
      stall_tick--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 35);
      2: out_stall_i <= ((cycle_cnt % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 99) < 80);
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL byte_pattern_stream_search_top");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= val;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
    end
  endtask

  // Load gen_pat into the DUT along with length and mode.
  task automatic set_search(input logic [4:0] len_field, input logic nonov);
    logic [63:0] lo;
    logic [63:0] hi;
    begin
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = gen_pat[k];
        hi[8*k +: 8] = gen_pat[k+8];
      end
      gen_len = (len_field == 0) ? 1 : ((len_field > 16) ? 16 : len_field);
      write_reg(CFG_PATTERN_LENGTH, {59'd0, len_field});
      write_reg(CFG_PATTERN_LOW, lo);
      write_reg(CFG_PATTERN_HIGH, hi);
      write_reg(CFG_NON_OVERLAP, {63'd0, nonov});
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic first, input logic last);
    stream_byte_t s;
    begin
      s.data = b;
      s.first = first;
      s.last = last;
      pending_bytes.insert(pending_bytes.size(), s);
      bytes_queued++;
    end
  endtask

  // Stream of at least n bytes, dense with whole and partial pattern copies.
  task automatic add_stream(input int unsigned n, input logic fresh);
    logic [7:0] body[$];
    int unsigned r;
    int unsigned cut;
    begin
      while (body.size() < n) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          for (int k = 0; k < gen_len; k++) body.insert(body.size(), gen_pat[k]);
        end else if (r < 35) begin
          cut = (gen_len > 1) ? $urandom_range(1, gen_len - 1) : 1;
          for (int k = 0; k < cut; k++) body.insert(body.size(), gen_pat[k]);
        end else if (r < 80) begin
          body.insert(body.size(), gen_pat[$urandom_range(0, gen_len - 1)]);
        end else begin
          body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
      end
      // the tail sometimes stays open, and a stray last may fall mid-stream
      for (int i = 0; i < body.size(); i++)
        add_byte(body[i], fresh && (i == 0),
                 ((i == body.size() - 1) && ($urandom_range(0, 7) != 0)) ||
                 ($urandom_range(0, 29) == 0));
    end
  endtask

  // Block is idle once every byte is in and every result is out.
  task automatic wait_idle();
    begin
      while (pending_bytes.size() != 0 || in_valid_i || expected_hits.size() != 0)
        @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
  endtask

  // main sequence
  initial begin
    logic [4:0]  len_field;
    int unsigned style;
    int unsigned target;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PATTERN_LENGTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    first_byte_i = 1'b0;
    last_byte_i = 1'b0;
    out_stall_i = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    bytes_queued = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_tick = 0;
    for (int k = 0; k < 16; k++) gen_pat[k] = 8'h00;
    gen_len = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: one-byte pattern 0x00, overlapping; data continues past last
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b1);
    wait_idle();

    // repeated bytes, non-overlapping: each hit bars the next two bytes
    for (int k = 0; k < 16; k++) gen_pat[k] = 8'h61;
    set_search(5'd3, 1'b1);
    for (int i = 0; i < 6; i++) add_byte(8'h61, i == 0, i == 5);
    wait_idle();

    // zero length acts as one byte
    gen_pat[0] = 8'hFF;
    set_search(5'd0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // oversized length clamps to 16; a full 16-byte hit at the last byte
    for (int k = 0; k < 16; k++) gen_pat[k] = 8'($urandom_range(0, 255));
    gen_pat[0] = 8'h00;
    gen_pat[15] = 8'hFF;
    set_search(5'd31, 1'b1);
    for (int i = 0; i < 16; i++) add_byte(gen_pat[i], i == 0, i == 15);
    wait_idle();

    // random phases, each with its own pattern, length and mode
    target = bytes_queued + RANDOM_ITEMS;
    while (bytes_queued < target) begin
      case ($urandom_range(0, 9))
        0: len_field = 5'd0;
        1: len_field = 5'd16;
        2: len_field = 5'($urandom_range(17, 31));
        3: len_field = 5'd1;
        default: len_field = 5'($urandom_range(2, 8));
      endcase
      style = $urandom_range(0, 1);
      for (int k = 0; k < 16; k++) begin
        if (style == 0) begin
          case ($urandom_range(0, 2))
            0: gen_pat[k] = 8'h00;
            1: gen_pat[k] = 8'hFF;
            default: gen_pat[k] = 8'h5A;
          endcase
        end else begin
          gen_pat[k] = 8'($urandom_range(0, 255));
        end
      end
      set_search(len_field, 1'($urandom_range(0, 1)));
      // the first stream of a phase may carry on from the previous setting
      for (int s = $urandom_range(1, 3); s > 0; s--)
        add_stream($urandom_range(1, 40), ($urandom_range(0, 2) != 0));
      wait_idle();
    end

    if (mismatch_cnt == 0 && expected_hits.size() == 0) begin
      $display("PASS byte_pattern_stream_search_top");
    end else begin
      $display("FAIL byte_pattern_stream_search_top");
    end
    $finish;
  end

endmodule
